/* design/lp2sc_pkg.sv */
// ----------------------------------------------------------------------------
// lp2sc_pkg
// Types and constants shared by the length-prefixed to start-code converter.
// ----------------------------------------------------------------------------
package lp2sc_pkg;

    localparam int unsigned LenFieldW   = 3;
    localparam int unsigned MaxOutW     = 25;
    localparam int unsigned SizeW       = 32;
    localparam int unsigned CfgIndexW   = 2;
    localparam int unsigned StartCodeLen = 4;

    localparam logic [CfgIndexW-1:0] CFG_LENGTH_FIELD_BYTES = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_MAX_OUTPUT_BYTES   = 2'd1;

    localparam logic [LenFieldW-1:0] LEN_FIELD_RESET  = 3'd4;
    localparam logic [MaxOutW-1:0]   MAX_OUTPUT_RESET = 25'd262144;

    localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
    localparam logic [7:0] SC_LAST_BYTE = 8'h01;

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             sample_first;
        logic [SizeW-1:0] smp_len;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       sample_done;
        logic       truncated;
        logic       run_last;
    } t_out;

    // Out-of-range widths clamp: zero acts as one, five to seven act as four.
    function automatic logic [LenFieldW-1:0] eff_length_width(
        input logic [LenFieldW-1:0] w
    );
        logic [LenFieldW-1:0] r;
        if (w == '0) begin
            r = 3'd1;
        end else if (w > 3'd4) begin
            r = 3'd4;
        end else begin
            r = w;
        end
        return r;
    endfunction

endpackage

/* design/length_prefixed_to_start_code_nal_core.sv */
// ----------------------------------------------------------------------------
// length_prefixed_to_start_code_nal_core
// Converts length-prefixed NAL units to start-code delimited units, one
// sample byte per request.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_in_data  (t_in)
// out       output     o_out_valid / i_out_ready   o_out_data (t_out)
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A request is taken in every cycle when it causes one result, unless the output stalls.
// A completed length field that fits causes four results (the start code), so
// the input waits while the result register drains them.
// The result register lets a new request enter while its last result leaves.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module length_prefixed_to_start_code_nal_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lp2sc_pkg::t_in                  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lp2sc_pkg::t_out                 o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lp2sc_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [lp2sc_pkg::MaxOutW-1:0]   i_cfg_data
);
    import lp2sc_pkg::*;

    logic [LenFieldW-1:0] r_len_field_bytes;
    logic [MaxOutW-1:0]   r_max_output;

    t_phase               r_phase, n_phase;
    logic [LenFieldW-1:0] r_len_seen, n_len_seen;
    logic [SizeW-1:0]     r_unit_len, n_unit_len;
    logic [SizeW-1:0]     r_sample_rem, n_sample_rem;
    logic [SizeW-1:0]     r_unit_rem, n_unit_rem;
    logic [MaxOutW-1:0]   r_written, n_written;

    logic                 r_out_valid;
    logic [1:0]           r_cnt, n_cnt;
    logic                 r_sc, n_sc;
    t_out                 r_res, n_res;

    logic                 in_fire, out_fire;
    logic [SizeW-1:0]     rem_cur, rem_dec;
    logic [MaxOutW-1:0]   written_cur;
    logic [SizeW-1:0]     len_shift;
    logic [LenFieldW-1:0] seen_inc;
    logic [SizeW+1:0]     need;
    logic                 done;

    assign o_cfg_ready = 1'b1;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_in_ready  = !r_out_valid || (i_out_ready && (r_cnt == 2'd0));
    assign in_fire     = i_in_valid && o_in_ready;

    always_comb begin
        o_out_valid = r_out_valid;
        o_out_data  = r_res;
        if (r_sc) begin
            o_out_data.out_byte = (r_cnt == 2'd0) ? SC_LAST_BYTE : SC_ZERO_BYTE;
            o_out_data.run_last = (r_cnt == 2'd0);
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_len_seen   = r_len_seen;
        n_unit_len   = r_unit_len;
        n_sample_rem = r_sample_rem;
        n_unit_rem   = r_unit_rem;
        n_written    = r_written;
        n_cnt        = 2'd0;
        n_sc         = 1'b0;
        n_res        = '{out_byte: 8'd0, byte_valid: 1'b0, sample_done: 1'b0,
                         truncated: 1'b0, run_last: 1'b1};

        rem_cur     = r_sample_rem;
        written_cur = r_written;
        if (i_in_data.sample_first) begin
            rem_cur     = i_in_data.smp_len;
            written_cur = '0;
            n_phase     = PH_LENGTH;
            n_len_seen  = '0;
            n_unit_len  = '0;
            n_unit_rem  = '0;
            n_written   = '0;
        end
        n_sample_rem = rem_cur;
        rem_dec      = rem_cur - 1'b1;
        done         = (rem_dec == '0);
        len_shift    = {n_unit_len[SizeW-9:0], i_in_data.data_byte};
        seen_inc     = (n_len_seen == 3'd7) ? n_len_seen : n_len_seen + 1'b1;
        need         = '0;

        if (i_in_data.sample_first && (i_in_data.smp_len == '0)) begin
            n_res.sample_done = 1'b1;
        end else if (rem_cur == '0) begin
            n_res.sample_done = 1'b0;
        end else begin
            n_sample_rem      = rem_dec;
            n_res.sample_done = done;
            unique case (n_phase)
                PH_PAYLOAD: begin
                    n_written        = written_cur + 1'b1;
                    n_res.out_byte   = i_in_data.data_byte;
                    n_res.byte_valid = 1'b1;
                    if (r_unit_rem == 32'd1 || r_unit_rem == '0) begin
                        n_phase    = PH_LENGTH;
                        n_len_seen = '0;
                        n_unit_len = '0;
                        n_unit_rem = '0;
                    end else begin
                        n_unit_rem = r_unit_rem - 1'b1;
                    end
                end
                PH_LENGTH: begin
                    if ((n_len_seen == '0) && (written_cur >= r_max_output)) begin
                        n_phase         = PH_DROP;
                        n_res.truncated = 1'b1;
                    end else begin
                        n_unit_len = len_shift;
                        n_len_seen = seen_inc;
                        if (seen_inc >= eff_length_width(r_len_field_bytes)) begin
                            need = {2'b00, len_shift} + {9'd0, written_cur}
                                 + (SizeW+2)'(StartCodeLen);
                            if ((len_shift > rem_dec)
                                || (need > {9'd0, r_max_output})) begin
                                n_phase         = PH_DROP;
                                n_res.truncated = 1'b1;
                            end else begin
                                n_written        = written_cur
                                                 + MaxOutW'(StartCodeLen);
                                n_len_seen       = '0;
                                n_sc             = 1'b1;
                                n_cnt            = 2'd3;
                                n_res.byte_valid = 1'b1;
                                n_res.run_last   = 1'b0;
                                if (len_shift == '0) begin
                                    n_phase    = PH_LENGTH;
                                    n_unit_len = '0;
                                    n_unit_rem = '0;
                                end else begin
                                    n_phase    = PH_PAYLOAD;
                                    n_unit_rem = len_shift;
                                end
                            end
                        end else if (done) begin
                            n_phase         = PH_LENGTH;
                            n_len_seen      = '0;
                            n_unit_len      = '0;
                            n_unit_rem      = '0;
                            n_res.truncated = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase         = PH_DROP;
                    n_res.truncated = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_field_bytes <= LEN_FIELD_RESET;
            r_max_output      <= MAX_OUTPUT_RESET;
        end else if (i_cfg_valid) begin
            priority if (i_cfg_index == CFG_LENGTH_FIELD_BYTES) begin
                r_len_field_bytes <= i_cfg_data[LenFieldW-1:0];
            end else if (i_cfg_index == CFG_MAX_OUTPUT_BYTES) begin
                r_max_output <= i_cfg_data;
            end else begin
                r_max_output <= r_max_output;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LENGTH;
            r_len_seen   <= '0;
            r_unit_len   <= '0;
            r_sample_rem <= '0;
            r_unit_rem   <= '0;
            r_written    <= '0;
        end else if (in_fire) begin
            r_phase      <= n_phase;
            r_len_seen   <= n_len_seen;
            r_unit_len   <= n_unit_len;
            r_sample_rem <= n_sample_rem;
            r_unit_rem   <= n_unit_rem;
            r_written    <= n_written;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= 2'd0;
            r_sc        <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
            r_cnt       <= n_cnt;
            r_sc        <= n_sc;
        end else if (out_fire) begin
            if (r_cnt == 2'd0) begin
                r_out_valid <= 1'b0;
                r_sc        <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

    a_multi_is_start_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.run_last) |-> (r_sc && o_out_data.byte_valid))
        else $error("multi-result run that is not a start code");

    a_trunc_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.truncated) |-> !o_out_data.byte_valid)
        else $error("dropped byte marked as carrying output");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_cnt != 2'd0)) |-> !o_in_ready)
        else $error("input taken while a start code is still draining");

    a_cnt_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> (r_out_valid && r_sc))
        else $error("result count without a pending start code");

    a_sc_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && (r_cnt != 2'd0)) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("start code count did not advance");

endmodule

/* tb/nal_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nal_stream_checker
// Watches the request, result and register channels of the length-prefixed
// to start-code converter. It keeps its own copy of the conversion state and
// predicts the results of every accepted request. Each accepted result is
// then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module nal_stream_checker
    import lp2sc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in                  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out                 i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [MaxOutW-1:0]   i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [LenFieldW-1:0] cfg_width;
    logic [MaxOutW-1:0]   cfg_max;

    t_phase               nal_phase;
    logic [2:0]           len_seen;
    logic [31:0]          unit_len;
    logic [31:0]          smp_left;
    logic [31:0]          unit_left;
    logic [MaxOutW-1:0]   written;

    t_out                 pending_results[$];
    t_out                 want;
    int                   mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void open_length();
        nal_phase = PH_LENGTH;
        len_seen  = '0;
        unit_len  = '0;
        unit_left = '0;
    endfunction

    function automatic void add_result(input logic [7:0] b, input logic v, input logic d,
                                       input logic t, input logic l);
        t_out r;
        r.out_byte    = b;
        r.byte_valid  = v;
        r.sample_done = d;
        r.truncated   = t;
        r.run_last    = l;
        pending_results = {pending_results, r};
    endfunction

    function automatic void log_failure(input string what, input t_out exp_r, input t_out got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected byte %02h valid %b done %b trunc %b last %b,",
                     $time, what, exp_r.out_byte, exp_r.byte_valid, exp_r.sample_done,
                     exp_r.truncated, exp_r.run_last,
                     " got byte %02h valid %b done %b trunc %b last %b",
                     got.out_byte, got.byte_valid, got.sample_done, got.truncated,
                     got.run_last);
        end
    endfunction

    task automatic convert_byte(input t_in req);
        logic                 done;
        logic [63:0]          need;
        logic [LenFieldW-1:0] width;
        if (req.sample_first) begin
            smp_left = req.smp_len;
            written  = '0;
            open_length();
            if (req.smp_len == '0) begin
                add_result(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
                return;
            end
        end
        if (smp_left == '0) begin
            add_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
            return;
        end
        smp_left = smp_left - 1;
        done     = (smp_left == '0);

        if (nal_phase == PH_PAYLOAD) begin
            written = written + 1'b1;
            if (unit_left != '0) unit_left = unit_left - 1;
            if (unit_left == '0) open_length();
            add_result(req.data_byte, 1'b1, done, 1'b0, 1'b1);
            return;
        end

        if (nal_phase == PH_LENGTH) begin
            if (len_seen == '0 && written >= cfg_max) begin
                nal_phase = PH_DROP;
            end else begin
                unit_len = {unit_len[23:0], req.data_byte};
                if (len_seen < 3'd7) len_seen = len_seen + 1'b1;
                width = (cfg_width == '0) ? 3'd1 : (cfg_width > 3'd4) ? 3'd4 : cfg_width;
                if (len_seen >= width) begin
                    need = written;
                    need = need + StartCodeLen + unit_len;
                    if (unit_len > smp_left || need > cfg_max) begin
                        nal_phase = PH_DROP;
                    end else begin
                        written = written + StartCodeLen;
                        if (unit_len == '0) begin
                            open_length();
                        end else begin
                            nal_phase = PH_PAYLOAD;
                            unit_left = unit_len;
                            len_seen  = '0;
                        end
                        add_result(SC_ZERO_BYTE, 1'b1, done, 1'b0, 1'b0);
                        add_result(SC_ZERO_BYTE, 1'b1, done, 1'b0, 1'b0);
                        add_result(SC_ZERO_BYTE, 1'b1, done, 1'b0, 1'b0);
                        add_result(SC_LAST_BYTE, 1'b1, done, 1'b0, 1'b1);
                        return;
                    end
                end else if (done) begin
                    open_length();
                    add_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
                    return;
                end else begin
                    add_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                    return;
                end
            end
        end

        nal_phase = PH_DROP;
        add_result(8'h00, 1'b0, done, 1'b1, 1'b1);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width = LEN_FIELD_RESET;
            cfg_max   = MAX_OUTPUT_RESET;
            open_length();
            smp_left  = '0;
            written   = '0;
            pending_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                convert_byte(i_in_data);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LENGTH_FIELD_BYTES: cfg_width = i_cfg_data[LenFieldW-1:0];
                    CFG_MAX_OUTPUT_BYTES:   cfg_max = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    log_failure("unexpected result", '0, i_out_data);
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_data !== want) begin
                        log_failure("result mismatch", want, i_out_data);
                    end
                end
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

/* tb/tb_length_prefixed_to_start_code_nal_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_to_start_code_nal_core
// Drives length-prefixed samples into the converter: a short directed set of
// corner cases, then random well-formed, cut, oversized and corrupted samples
// mixed with stray bytes, under several register settings and idling patterns.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_length_prefixed_to_start_code_nal_core;
    import lp2sc_pkg::*;

    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BLOCK_ITEMS    = 24;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in                  in_data;
    logic                 out_valid;
    logic                 out_ready;
    t_out                 out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index;
    logic [MaxOutW-1:0]   cfg_data;

    int                   fail_count;
    int                   pending;
    int                   snd_idle_pct;
    int                   rcv_idle_pct;
    int                   hold_reqs;
    int                   stall_cycles;
    int                   sample_bytes_sent;
    int                   len_width;
    logic [7:0]           smp_bytes[$];

    logic [LenFieldW-1:0] blk_w [9] = '{3'd1, 3'd2, 3'd4, 3'd3, 3'd0, 3'd7, 3'd6, 3'd5, 3'd2};
    logic [MaxOutW-1:0]   blk_max [9] = '{25'd4, 25'd16777216, 25'd262144, 25'd20,
                                          25'd16777215, 25'd12, 25'd40, 25'd4, 25'd30};

    length_prefixed_to_start_code_nal_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    nal_stream_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver serves each hold request with a long stretch of back-pressure.
    initial begin
        int served;
        served    = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_reqs != served) begin
                served++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic first, input logic [31:0] size);
        t_in req;
        req.data_byte    = b;
        req.sample_first = first;
        req.smp_len      = size;
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sample_bytes_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_cfg(input logic [LenFieldW-1:0] w, input logic [MaxOutW-1:0] max_out);
        cfg_index <= CFG_LENGTH_FIELD_BYTES;
        cfg_data  <= MaxOutW'(w);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_MAX_OUTPUT_BYTES;
        cfg_data  <= max_out;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        len_width = (w == '0) ? 1 : (w > 3'd4) ? 4 : int'(w);
    endtask

    task automatic send_sample(input logic [31:0] size);
        for (int i = 0; i < smp_bytes.size(); i++) begin
            push_byte(smp_bytes[i], i == 0, (i == 0) ? size : $urandom());
        end
    endtask

    task automatic run_sample();
        int unsigned kind;
        int unsigned units;
        int unsigned len;
        logic [31:0] size;
        kind = $urandom_range(99);
        if (kind >= 90) begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(3) == 0) begin
                    push_byte($urandom_range(255), 1'b1,
                              $urandom_range(1) ? 32'd0 : $urandom_range(1, 3));
                end else begin
                    push_byte($urandom_range(255), 1'b0, $urandom());
                end
            end
            return;
        end
        smp_bytes.delete();
        units = $urandom_range(1, 3);
        for (int u = 0; u < units; u++) begin
            len = $urandom_range(0, 5);
            if (kind >= 80 && u == units - 1) begin
                repeat (len_width) smp_bytes = {smp_bytes, 8'($urandom_range(255))};
                len = $urandom_range(0, 2);
            end else begin
                for (int j = len_width - 1; j >= 0; j--) begin
                    smp_bytes = {smp_bytes, 8'(len >> (8 * j))};
                end
            end
            repeat (len) smp_bytes = {smp_bytes, 8'($urandom_range(255))};
        end
        size = smp_bytes.size();
        if (kind >= 70 && kind < 80) begin
            size = $urandom_range(1) ? size + $urandom_range(1, 50) : ($urandom() | 32'h8000_0000);
        end else if (kind >= 60 && kind < 70) begin
            size = (size > 3) ? size - $urandom_range(1, 3) : size - 1;
        end
        send_sample(size);
    endtask

    initial begin
        int k;
        int target;
        logic [MaxOutW-1:0] next_max;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        in_data           = '0;
        cfg_valid         = 1'b0;
        cfg_index         = CFG_LENGTH_FIELD_BYTES;
        cfg_data          = '0;
        snd_idle_pct      = 0;
        rcv_idle_pct      = 0;
        hold_reqs         = 0;
        sample_bytes_sent = 0;
        len_width         = 4;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
        push_byte(8'hAA, 1'b1, 32'd0);
        smp_bytes = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_sample(32'd10);
        smp_bytes = '{8'h00, 8'h00};
        send_sample(32'd2);
        smp_bytes = '{8'h00, 8'h00, 8'h00, 8'h09, 8'h77};
        send_sample(32'd5);
        smp_bytes = '{8'h00, 8'h00, 8'h00};
        send_sample(32'd5);
        drain();
        write_cfg(3'd2, MAX_OUTPUT_RESET);
        push_byte(8'h01, 1'b0, $urandom());
        push_byte(8'h5A, 1'b0, $urandom());

        for (int p = 0; p < 3; p++) begin
            snd_idle_pct = (p == 0) ? 8 : (p == 1) ? 58 : 0;
            rcv_idle_pct <= (p == 0) ? 58 : (p == 1) ? 8 : 0;
            for (int b = 0; b < 3; b++) begin
                k = 3 * p + b;
                drain();
                next_max = (k == 7) ? MaxOutW'($urandom_range(4, 16777216)) : blk_max[k];
                write_cfg(blk_w[k], next_max);
                if (b == 0 && p != 1) hold_reqs <= hold_reqs + 1;
                target = sample_bytes_sent + BLOCK_ITEMS;
                while (sample_bytes_sent < target) run_sample();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
design/lp2sc_pkg.sv
design/length_prefixed_to_start_code_nal_core.sv
tb/nal_stream_checker.sv
tb/tb_length_prefixed_to_start_code_nal_core.sv
